>>> rtl/strict_priority_class_queues_defines.svh
// assertion macros for the strict priority class queues
// used by scpq_ctrl and scpq_acct, expects clk and arst_n in scope
`ifndef STRICT_PRIORITY_CLASS_QUEUES_DEFINES_SVH
`define STRICT_PRIORITY_CLASS_QUEUES_DEFINES_SVH
`ifndef SYNTH
`define SCPQ_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SCPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SCPQ_ASSERT_SAME(lbl, ante, cons, msg)
`define SCPQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/scpq_pkg.sv
// types, sizes and helpers for the strict priority class queues
// used by the rtl modules of the block other than scpq_ram, depends on nothing
`default_nettype none

package scpq_pkg;

	localparam int NUM_CLASSES = 2;
	localparam int QUEUE_DEPTH = 64;

	localparam int CLS_W = $clog2(NUM_CLASSES);
	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W = CLS_W + IDX_W;
	localparam int TOT_W = 16 + $clog2(NUM_CLASSES);
	localparam int REC_W = 48;

	localparam logic REQ_ENQ = 1'b0;
	localparam logic REQ_DEQ = 1'b1;

	typedef logic [CLS_W-1:0] cls_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic        req_type;
		logic        cust_class;
		logic [15:0] customer_id;
		logic [15:0] arrival_tenths;
		logic [15:0] service_tenths;
		logic [15:0] now_tenths;
	} in_t;

	typedef struct packed {
		logic        accepted;
		logic        out_class;
		logic [15:0] out_customer_id;
		logic [15:0] out_service_tenths;
		logic [15:0] wait_tenths;
		logic [6:0]  queue_length;
		logic [15:0] class_served_count;
		logic [31:0] class_wait_total;
		logic        all_served;
	} out_t;

	// record layout in the queue memory
	typedef struct packed {
		logic [15:0] id;
		logic [15:0] arrival;
		logic [15:0] service;
	} rec_t;

	// decision for one request, handed from pointer stage to accounting stage
	typedef struct packed {
		logic        valid;
		logic        is_deq;
		logic        hit;
		cls_t        cls;
		cnt_t        fill_after;
		logic [15:0] now;
	} ctrl_t;

	function automatic idx_t next_slot(input idx_t i);
		next_slot = (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

endpackage

`default_nettype wire

>>> rtl/strict_priority_class_queues.sv
// Two class customer queues under strict priority. A request is taken at any
// clock edge with start high (busy is always low), one request per cycle, and
// its result appears with done after the registered read of the record memory
// and the wait and totals accounting into the result register. done lasts one
// cycle and the receiver cannot stall it, so results must be captured when
// shown. Results come out in request order. The user must write
// total_customers through cfg_we/cfg_wdata only while no request is in flight;
// the block itself does not enforce this.
`default_nettype none

module strict_priority_class_queues (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire scpq_pkg::in_t  req,
	input  wire logic           cfg_we,
	input  wire logic [15:0]    cfg_wdata,
	output logic                done,
	output scpq_pkg::out_t      rsp
);

	logic                          take;
	logic                          ram_we;
	logic [scpq_pkg::ADDR_W-1:0]   ram_waddr;
	scpq_pkg::rec_t                ram_wdata;
	logic                          ram_re;
	logic [scpq_pkg::ADDR_W-1:0]   ram_raddr;
	logic [scpq_pkg::REC_W-1:0]    ram_rdata;
	scpq_pkg::ctrl_t               s1;

	// fully pipelined, never refuses a request
	assign busy = 1'b0;
	assign take = start && !busy;

	scpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.req       (req),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.s1        (s1)
	);

	scpq_ram #(
		.DATA_W (scpq_pkg::REC_W),
		.ADDR_W (scpq_pkg::ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	scpq_acct u_acct (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s1        (s1),
		.rec       (scpq_pkg::rec_t'(ram_rdata)),
		.done      (done),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

>>> rtl/scpq_ram.sv
// simple dual port memory, one write and one registered read per cycle
// generic, holds the customer records of all class queues
`default_nettype none

module scpq_ram #(
	parameter int DATA_W = 48,
	parameter int ADDR_W = 7
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/scpq_ctrl.sv
// queue pointers and fill counts, picks the class and slot for each request
// uses scpq_pkg, drives the record memory ports and the stage one register
`default_nettype none
`include "strict_priority_class_queues_defines.svh"

module scpq_ctrl (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     take,
	input  wire scpq_pkg::in_t            req,
	output logic                          ram_we,
	output logic [scpq_pkg::ADDR_W-1:0]   ram_waddr,
	output scpq_pkg::rec_t                ram_wdata,
	output logic                          ram_re,
	output logic [scpq_pkg::ADDR_W-1:0]   ram_raddr,
	output scpq_pkg::ctrl_t               s1
);

	scpq_pkg::idx_t  rd_idx_q [scpq_pkg::NUM_CLASSES];
	scpq_pkg::idx_t  wr_idx_q [scpq_pkg::NUM_CLASSES];
	scpq_pkg::cnt_t  fill_q   [scpq_pkg::NUM_CLASSES];
	scpq_pkg::ctrl_t s1_q;

	scpq_pkg::cls_t  enq_cls;
	logic            enq_ok;
	scpq_pkg::cls_t  deq_cls;
	logic            deq_hit;
	logic            is_deq;
	scpq_pkg::ctrl_t s1_d;

	assign is_deq  = (req.req_type == scpq_pkg::REQ_DEQ);
	assign enq_cls = scpq_pkg::CLS_W'(req.cust_class);
	assign enq_ok  = (fill_q[enq_cls] != scpq_pkg::CNT_W'(scpq_pkg::QUEUE_DEPTH));

	// highest numbered non-empty class wins
	always_comb begin
		deq_hit = 1'b0;
		deq_cls = '0;
		for (int c = 0; c < scpq_pkg::NUM_CLASSES; c++) begin
			if (fill_q[c] != '0) begin
				deq_hit = 1'b1;
				deq_cls = scpq_pkg::CLS_W'(c);
			end
		end
	end

	assign ram_we    = take && !is_deq && enq_ok;
	assign ram_waddr = {enq_cls, wr_idx_q[enq_cls]};
	assign ram_wdata = '{id: req.customer_id, arrival: req.arrival_tenths,
		service: req.service_tenths};
	assign ram_re    = take && is_deq;
	assign ram_raddr = {deq_cls, rd_idx_q[deq_cls]};

	always_comb begin
		s1_d.valid  = take;
		s1_d.is_deq = is_deq;
		s1_d.now    = req.now_tenths;
		if (is_deq) begin
			s1_d.hit        = deq_hit;
			s1_d.cls        = deq_cls;
			s1_d.fill_after = deq_hit ? fill_q[deq_cls] - 1'b1 : '0;
		end else begin
			s1_d.hit        = enq_ok;
			s1_d.cls        = enq_cls;
			s1_d.fill_after = fill_q[enq_cls] + scpq_pkg::CNT_W'(enq_ok);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < scpq_pkg::NUM_CLASSES; c++) begin
				rd_idx_q[c] <= '0;
				wr_idx_q[c] <= '0;
				fill_q[c]   <= '0;
			end
		end else if (take) begin
			if (is_deq) begin
				if (deq_hit) begin
					rd_idx_q[deq_cls] <= scpq_pkg::next_slot(rd_idx_q[deq_cls]);
					fill_q[deq_cls]   <= fill_q[deq_cls] - 1'b1;
				end
			end else if (enq_ok) begin
				wr_idx_q[enq_cls] <= scpq_pkg::next_slot(wr_idx_q[enq_cls]);
				fill_q[enq_cls]   <= fill_q[enq_cls] + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q <= '0;
		end else begin
			s1_q <= s1_d;
		end
	end

	assign s1 = s1_q;

	`SCPQ_ASSERT_NEXT(a_take_loads_s1, take, s1_q.valid, "request not carried to stage one")
	`SCPQ_ASSERT_SAME(a_enq_nonempty, s1_q.valid && s1_q.hit && !s1_q.is_deq,
		s1_q.fill_after != '0, "stored record left an empty queue")

endmodule

`default_nettype wire

>>> rtl/scpq_acct.sv
// per class served counts and wait totals, wait time and the result register
// uses scpq_pkg, fed by scpq_ctrl stage one and the record memory read data
`default_nettype none
`include "strict_priority_class_queues_defines.svh"

module scpq_acct (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic [15:0]     cfg_wdata,
	input  wire scpq_pkg::ctrl_t s1,
	input  wire scpq_pkg::rec_t  rec,
	output logic                 done,
	output scpq_pkg::out_t       rsp
);

	logic [15:0]              served_q [scpq_pkg::NUM_CLASSES];
	logic [31:0]              wsum_q   [scpq_pkg::NUM_CLASSES];
	logic [scpq_pkg::TOT_W-1:0] total_q;
	logic                     fin_q;
	logic [15:0]              tc_q;
	logic                     done_q;
	scpq_pkg::out_t           rsp_q;

	logic [15:0]              wait_t;
	logic [15:0]              served_cur;
	logic [31:0]              wsum_cur;
	logic                     served_inc;
	logic [15:0]              served_new;
	logic [32:0]              wsum_sum;
	logic [31:0]              wsum_new;
	logic [scpq_pkg::TOT_W-1:0] total_new;
	logic                     fin_new;
	logic                     serve;
	scpq_pkg::out_t           rsp_d;

	assign wait_t     = (s1.now > rec.arrival) ? s1.now - rec.arrival : '0;
	assign served_cur = served_q[s1.cls];
	assign wsum_cur   = wsum_q[s1.cls];
	assign served_inc = (served_cur != 16'hFFFF);
	assign served_new = served_cur + 16'(served_inc);
	assign wsum_sum   = {1'b0, wsum_cur} + 33'(wait_t);
	assign wsum_new   = wsum_sum[32] ? 32'hFFFF_FFFF : wsum_sum[31:0];
	// running total moves only while the class count still moves
	assign total_new  = total_q + scpq_pkg::TOT_W'(served_inc);
	assign fin_new    = fin_q || (total_new >= scpq_pkg::TOT_W'(tc_q));
	assign serve      = s1.valid && s1.is_deq && s1.hit;

	always_comb begin
		rsp_d = '0;
		rsp_d.all_served = serve ? fin_new : fin_q;
		if (s1.is_deq) begin
			if (s1.hit) begin
				rsp_d.accepted           = 1'b1;
				rsp_d.out_class          = s1.cls[0];
				rsp_d.out_customer_id    = rec.id;
				rsp_d.out_service_tenths = rec.service;
				rsp_d.wait_tenths        = wait_t;
				rsp_d.queue_length       = 7'(s1.fill_after);
				rsp_d.class_served_count = served_new;
				rsp_d.class_wait_total   = wsum_new;
			end
		end else begin
			rsp_d.accepted           = s1.hit;
			rsp_d.out_class          = s1.cls[0];
			rsp_d.queue_length       = 7'(s1.fill_after);
			rsp_d.class_served_count = served_cur;
			rsp_d.class_wait_total   = wsum_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < scpq_pkg::NUM_CLASSES; c++) begin
				served_q[c] <= '0;
				wsum_q[c]   <= '0;
			end
			total_q <= '0;
			fin_q   <= 1'b0;
		end else if (serve) begin
			served_q[s1.cls] <= served_new;
			wsum_q[s1.cls]   <= wsum_new;
			total_q          <= total_new;
			fin_q            <= fin_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q <= 16'd1;
		end else if (cfg_we) begin
			tc_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		rsp_q <= rsp_d;
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	`SCPQ_ASSERT_NEXT(a_s1_gives_done, s1.valid, done_q, "stage one request lost")
	`SCPQ_ASSERT_NEXT(a_no_extra_done, !s1.valid, !done_q, "result without a request")
	`SCPQ_ASSERT_NEXT(a_fin_sticky, fin_q, fin_q, "all served flag dropped")

endmodule

`default_nettype wire

>>> test/tb_top.sv
// self-checking testbench for strict_priority_class_queues
// drives requests and the customer goal register, predicts each result in sv or takes it from the table
// depends on scpq_pkg and the rtl of the block only
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 4;
	localparam int PHASE_ITEMS = 150;

	typedef enum int {TRAFFIC_FILL, TRAFFIC_MIX, TRAFFIC_DRAIN} traffic_t;

	typedef struct {
		scpq_pkg::in_t  req;
		bit             typed;
		scpq_pkg::out_t want;
	} plan_row_t;

	logic           clk = 1'b0;
	logic           arst_n;
	logic           start;
	logic           busy;
	scpq_pkg::in_t  req;
	logic           cfg_we;
	logic [15:0]    cfg_wdata;
	logic           done;
	scpq_pkg::out_t rsp;

	// predicted queue contents and class totals
	scpq_pkg::rec_t q_rec [scpq_pkg::NUM_CLASSES][scpq_pkg::QUEUE_DEPTH];
	int             q_head [scpq_pkg::NUM_CLASSES];
	int             q_tail [scpq_pkg::NUM_CLASSES];
	int             q_fill [scpq_pkg::NUM_CLASSES];
	logic [15:0]    q_served [scpq_pkg::NUM_CLASSES];
	logic [31:0]    q_wait_sum [scpq_pkg::NUM_CLASSES];
	bit             served_all;
	logic [15:0]    customer_goal;

	scpq_pkg::out_t rsp_due [$];
	plan_row_t      plan [$];
	logic [15:0]    sim_clock;
	bit             idle_on;
	int             errors;
	int             stall_cycles;
	int             n_req;
	int             n_rsp;
	int             n_full;
	int             n_empty;

	strict_priority_class_queues dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.rsp       (rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic scpq_pkg::in_t mk_req(input logic rt, input logic cls,
			input logic [15:0] id, input logic [15:0] arr, input logic [15:0] srv,
			input logic [15:0] now);
		scpq_pkg::in_t r;
		r.req_type = rt;
		r.cust_class = cls;
		r.customer_id = id;
		r.arrival_tenths = arr;
		r.service_tenths = srv;
		r.now_tenths = now;
		return r;
	endfunction

	function automatic scpq_pkg::out_t mk_rsp(input logic acc, input logic cls,
			input logic [15:0] id, input logic [15:0] srv, input logic [15:0] wt,
			input logic [6:0] qlen, input logic [15:0] served, input logic [31:0] total,
			input logic flag);
		scpq_pkg::out_t o;
		o.accepted = acc;
		o.out_class = cls;
		o.out_customer_id = id;
		o.out_service_tenths = srv;
		o.wait_tenths = wt;
		o.queue_length = qlen;
		o.class_served_count = served;
		o.class_wait_total = total;
		o.all_served = flag;
		return o;
	endfunction

	// applies one request to the predicted queues and returns its result
	function automatic scpq_pkg::out_t queue_outcome(input scpq_pkg::in_t r);
		scpq_pkg::out_t o;
		scpq_pkg::rec_t hd;
		int             q;
		int             c;
		int             tot;
		logic [15:0]    w;
		logic [32:0]    sum;
		o = '0;
		if (r.req_type == scpq_pkg::REQ_ENQ) begin
			q = int'(r.cust_class);
			o.out_class = r.cust_class;
			if (q_fill[q] < scpq_pkg::QUEUE_DEPTH) begin
				q_rec[q][q_tail[q]] = '{id: r.customer_id, arrival: r.arrival_tenths,
					service: r.service_tenths};
				q_tail[q] = (q_tail[q] + 1) % scpq_pkg::QUEUE_DEPTH;
				q_fill[q]++;
				o.accepted = 1'b1;
			end
			o.queue_length = 7'(q_fill[q]);
			o.class_served_count = q_served[q];
			o.class_wait_total = q_wait_sum[q];
		end else begin
			q = -1;
			for (c = scpq_pkg::NUM_CLASSES - 1; c >= 0; c--)
				if (q < 0 && q_fill[c] != 0) q = c;
			if (q >= 0) begin
				hd = q_rec[q][q_head[q]];
				w = (r.now_tenths > hd.arrival) ? r.now_tenths - hd.arrival : 16'h0000;
				q_head[q] = (q_head[q] + 1) % scpq_pkg::QUEUE_DEPTH;
				q_fill[q]--;
				if (q_served[q] != 16'hFFFF) q_served[q]++;
				sum = {1'b0, q_wait_sum[q]} + 33'(w);
				q_wait_sum[q] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
				tot = 0;
				for (c = 0; c < scpq_pkg::NUM_CLASSES; c++) tot += int'(q_served[c]);
				if (tot >= int'(customer_goal)) served_all = 1'b1;
				o.accepted = 1'b1;
				o.out_class = 1'(q);
				o.out_customer_id = hd.id;
				o.out_service_tenths = hd.service;
				o.wait_tenths = w;
				o.queue_length = 7'(q_fill[q]);
				o.class_served_count = q_served[q];
				o.class_wait_total = q_wait_sum[q];
			end
		end
		o.all_served = served_all;
		return o;
	endfunction

	// mostly a running clock with short waits, sometimes fully random times
	function automatic scpq_pkg::in_t random_request(input traffic_t mode,
			input logic lead_cls);
		scpq_pkg::in_t r;
		int            enq_pct;
		enq_pct = (mode == TRAFFIC_FILL) ? 85 : (mode == TRAFFIC_DRAIN) ? 15 : 50;
		r.req_type = ($urandom_range(99) < enq_pct) ? scpq_pkg::REQ_ENQ : scpq_pkg::REQ_DEQ;
		r.cust_class = ($urandom_range(99) < 85) ? lead_cls : ~lead_cls;
		r.customer_id = 16'($urandom);
		r.service_tenths = 16'($urandom);
		sim_clock += 16'($urandom_range(40));
		if ($urandom_range(99) < 75) begin
			r.arrival_tenths = sim_clock - 16'($urandom_range(30));
			r.now_tenths = sim_clock + 16'($urandom_range(600));
		end else begin
			r.arrival_tenths = 16'($urandom);
			r.now_tenths = 16'($urandom);
		end
		return r;
	endfunction

	task automatic plan_add(input scpq_pkg::in_t r, input bit typed,
			input scpq_pkg::out_t want);
		plan_row_t row;
		row.req = r;
		row.typed = typed;
		row.want = want;
		plan.push_back(row);
	endtask

	task automatic send_request(input scpq_pkg::in_t r, input bit typed,
			input scpq_pkg::out_t want);
		scpq_pkg::out_t got;
		if (idle_on && $urandom_range(99) < 34) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 34);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy !== 1'b0);
		got = queue_outcome(r);
		rsp_due.push_back(typed ? want : got);
		n_req++;
		if (!got.accepted) begin
			if (r.req_type == scpq_pkg::REQ_ENQ) n_full++;
			else n_empty++;
		end
	endtask

	task automatic settle();
		start <= 1'b0;
		while (rsp_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_goal(input logic [15:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		customer_goal = v;
	endtask

	task automatic run_traffic(input int items);
		traffic_t mode;
		int       left;
		int       len;
		int       i;
		logic     lead;
		left = items;
		mode = TRAFFIC_FILL;
		while (left > 0) begin
			len = (mode == TRAFFIC_FILL) ? int'($urandom_range(110, 60))
				: int'($urandom_range(80, 20));
			lead = 1'($urandom);
			for (i = 0; i < len && left > 0; i++) begin
				send_request(random_request(mode, lead), 1'b0, '0);
				left--;
			end
			mode = (mode == TRAFFIC_FILL) ? TRAFFIC_MIX
				: (mode == TRAFFIC_MIX) ? TRAFFIC_DRAIN : TRAFFIC_FILL;
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		scpq_pkg::out_t want;
		if (arst_n === 1'b1) begin
			if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) stall_cycles = 0;
			else stall_cycles++;
			if (done === 1'b1) begin
				n_rsp++;
				if (rsp_due.size() == 0) begin
					errors++;
					$display("%0t: result with no request pending, expected none actual %p",
						$time, rsp);
				end else begin
					want = rsp_due.pop_front();
					check_field("accepted", want.accepted, rsp.accepted);
					check_field("out_class", want.out_class, rsp.out_class);
					check_field("out_customer_id", want.out_customer_id, rsp.out_customer_id);
					check_field("out_service_tenths", want.out_service_tenths,
						rsp.out_service_tenths);
					check_field("wait_tenths", want.wait_tenths, rsp.wait_tenths);
					check_field("queue_length", want.queue_length, rsp.queue_length);
					check_field("class_served_count", want.class_served_count,
						rsp.class_served_count);
					check_field("class_wait_total", want.class_wait_total, rsp.class_wait_total);
					check_field("all_served", want.all_served, rsp.all_served);
				end
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no request or result for %0d cycles", $time, stall_cycles);
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		int c;
		errors = 0;
		stall_cycles = 0;
		n_req = 0;
		n_rsp = 0;
		n_full = 0;
		n_empty = 0;
		sim_clock = 16'h0000;
		idle_on = 1'b1;
		arst_n <= 1'b0;
		start <= 1'b0;
		req <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		for (c = 0; c < scpq_pkg::NUM_CLASSES; c++) begin
			q_head[c] = 0;
			q_tail[c] = 0;
			q_fill[c] = 0;
			q_served[c] = '0;
			q_wait_sum[c] = '0;
		end
		served_all = 1'b0;
		customer_goal = 16'd1;

		// goal is 65535 here, so all_served stays low through this table
		plan_add(mk_req(scpq_pkg::REQ_DEQ, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b1,
			mk_rsp(1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 7'd0, 16'd0, 32'd0, 1'b0));
		plan_add(mk_req(scpq_pkg::REQ_ENQ, 1'b0, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF), 1'b1,
			mk_rsp(1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000, 7'd1, 16'd0, 32'd0, 1'b0));
		plan_add(mk_req(scpq_pkg::REQ_ENQ, 1'b1, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000), 1'b1,
			mk_rsp(1'b1, 1'b1, 16'h0000, 16'h0000, 16'h0000, 7'd1, 16'd0, 32'd0, 1'b0));
		plan_add(mk_req(scpq_pkg::REQ_ENQ, 1'b0, 16'h1234, 16'h000A, 16'h0005, 16'h0000), 1'b1,
			mk_rsp(1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000, 7'd2, 16'd0, 32'd0, 1'b0));
		// high class first, arrival after now gives zero wait
		plan_add(mk_req(scpq_pkg::REQ_DEQ, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b1,
			mk_rsp(1'b1, 1'b1, 16'h0000, 16'h0000, 16'h0000, 7'd0, 16'd1, 32'd0, 1'b0));
		plan_add(mk_req(scpq_pkg::REQ_DEQ, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF), 1'b1,
			mk_rsp(1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd1, 16'd1, 32'h0000_FFFF,
				1'b0));
		plan_add(mk_req(scpq_pkg::REQ_DEQ, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h000A), 1'b1,
			mk_rsp(1'b1, 1'b0, 16'h1234, 16'h0005, 16'h0000, 7'd0, 16'd2, 32'h0000_FFFF,
				1'b0));
		plan_add(mk_req(scpq_pkg::REQ_DEQ, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1,
			mk_rsp(1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 7'd0, 16'd0, 32'd0, 1'b0));
		plan_add(mk_req(scpq_pkg::REQ_ENQ, 1'b1, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA), 1'b0,
			'0);
		plan_add(mk_req(scpq_pkg::REQ_ENQ, 1'b1, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555), 1'b0,
			'0);
		plan_add(mk_req(scpq_pkg::REQ_ENQ, 1'b0, 16'h0001, 16'h0100, 16'h0020, 16'h0000), 1'b0,
			'0);
		plan_add(mk_req(scpq_pkg::REQ_DEQ, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h5554), 1'b0,
			'0);
		plan_add(mk_req(scpq_pkg::REQ_DEQ, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'hAAAB), 1'b0,
			'0);
		plan_add(mk_req(scpq_pkg::REQ_ENQ, 1'b1, 16'h00FF, 16'h0000, 16'h8000, 16'h7FFF), 1'b0,
			'0);
		plan_add(mk_req(scpq_pkg::REQ_DEQ, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h8000), 1'b0,
			'0);
		plan_add(mk_req(scpq_pkg::REQ_DEQ, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0100), 1'b0,
			'0);
		plan_add(mk_req(scpq_pkg::REQ_DEQ, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h1234), 1'b0,
			'0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_goal(16'hFFFF);
		foreach (plan[k]) send_request(plan[k].req, plan[k].typed, plan[k].want);

		write_goal(16'd1200);
		run_traffic(PHASE_ITEMS);
		write_goal(16'd30000);
		idle_on = 1'b0;
		run_traffic(PHASE_ITEMS);
		idle_on = 1'b1;
		write_goal(16'hFFFF);
		run_traffic(PHASE_ITEMS);

		write_goal(16'h0000);
		run_traffic(60);
		write_goal(16'h0001);
		settle();

		$display("ran %0d requests and checked %0d results", n_req, n_rsp);
		$display("%0d refused on a full queue, %0d dequeues on empty, goal swept 0 to 65535",
			n_full, n_empty);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
